### hdl/lup2_pkg.sv
// Shared constants, register codes and stage control types of the upsample-by-two interpolator.
package lup2_pkg;

    localparam int TAPS           = 10;
    localparam int UPSAMPLE_RATIO = 2;
    localparam int HALF_TAPS      = TAPS / UPSAMPLE_RATIO;
    localparam int EVEN_TAP       = HALF_TAPS - 1;
    localparam int COEF_BITS      = 18;
    localparam int FRAC_BITS      = 16;
    localparam int FILL_BITS      = 4;
    localparam int ADDR_BITS      = 5;

    localparam logic [FILL_BITS-1:0] TAPS_FILL = FILL_BITS'(TAPS);

    localparam logic signed [COEF_BITS-1:0] COEF_RESET [HALF_TAPS] = '{
        18'sd35, -18'sd405, 18'sd2268, -18'sd8820, 18'sd39690
    };

    typedef enum logic [2:0] {
        REG_COEF_OUTER  = 3'd0,
        REG_COEF_SECOND = 3'd1,
        REG_COEF_THIRD  = 3'd2,
        REG_COEF_FOURTH = 3'd3,
        REG_COEF_INNER  = 3'd4
    } lup2_reg_t;

    typedef struct packed {
        logic load_pair;
        logic load_prod;
    } lup2_mac_ctl_t;

    typedef struct packed {
        logic load_sum;
        logic load_out;
    } lup2_rs_ctl_t;

endpackage

### hdl/lup2_tap_cell.sv
// One cell of the sample window: holds a sample and takes its neighbour's on each shift.
module lup2_tap_cell import lup2_pkg::*; #(
    parameter int WIDTH = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    shift,
    input  logic signed [WIDTH-1:0] data_in,
    output logic signed [WIDTH-1:0] data_out
);

    logic signed [WIDTH-1:0] value_reg;
    logic signed [WIDTH-1:0] value_next;

    always_comb
    begin
        value_next = shift ? data_in : value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign data_out = value_reg;

endmodule

### hdl/lup2_mac.sv
// Symmetric tap pair: pre-adds two window samples, then multiplies the pair by its weight.
module lup2_mac import lup2_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                clk,
    input  lup2_mac_ctl_t                       ctl,
    input  logic signed [SAMPLE_BITS-1:0]       tap_lo,
    input  logic signed [SAMPLE_BITS-1:0]       tap_hi,
    input  logic signed [COEF_BITS-1:0]         coef,
    output logic signed [SAMPLE_BITS+COEF_BITS:0] product
);

    localparam int PAIR_W = SAMPLE_BITS + 1;
    localparam int PROD_W = PAIR_W + COEF_BITS;

    logic signed [PAIR_W-1:0] pair_reg;
    logic signed [PAIR_W-1:0] pair_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    always_comb
    begin
        pair_next = ctl.load_pair ? (PAIR_W'(tap_lo) + PAIR_W'(tap_hi)) : pair_reg;
        prod_next = ctl.load_prod ? (PROD_W'(pair_reg) * PROD_W'(coef)) : prod_reg;
    end

    // Payload only: the valid bits live with the flow control in the top level.
    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
        prod_reg <= prod_next;
    end

    assign product = prod_reg;

endmodule

### hdl/lup2_round_sat.sv
// Sums the five weighted pairs, rounds half up to whole samples and saturates to the sample range.
module lup2_round_sat import lup2_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                  clk,
    input  lup2_rs_ctl_t                          ctl,
    input  logic signed [SAMPLE_BITS+COEF_BITS:0] product [HALF_TAPS],
    output logic signed [SAMPLE_BITS-1:0]         odd_value,
    output logic                                  saturated
);

    localparam int PROD_W = SAMPLE_BITS + 1 + COEF_BITS;
    localparam int SUM_W  = PROD_W + 3;

    localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0] MAX_V    =
        SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] MIN_V    = ~MAX_V;

    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [SUM_W-1:0]       sum_next;
    logic signed [SUM_W-1:0]       shifted;
    logic signed [SAMPLE_BITS-1:0] odd_reg;
    logic signed [SAMPLE_BITS-1:0] odd_next;
    logic                          sat_reg;
    logic                          sat_next;

    always_comb
    begin
        sum_next = HALF_LSB;
        for (int i = 0; i < HALF_TAPS; i++)
        begin
            sum_next = sum_next + SUM_W'(product[i]);
        end
        if (!ctl.load_sum)
        begin
            sum_next = sum_reg;
        end
    end

    // An arithmetic shift of the sum is the floor of its quotient by the Q16 unit.
    always_comb
    begin
        shifted  = sum_reg >>> FRAC_BITS;
        odd_next = odd_reg;
        sat_next = sat_reg;
        if (ctl.load_out)
        begin
            if (shifted > MAX_V)
            begin
                odd_next = MAX_V[SAMPLE_BITS-1:0];
                sat_next = 1'b1;
            end
            else if (shifted < MIN_V)
            begin
                odd_next = MIN_V[SAMPLE_BITS-1:0];
                sat_next = 1'b1;
            end
            else
            begin
                odd_next = shifted[SAMPLE_BITS-1:0];
                sat_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        odd_reg <= odd_next;
        sat_reg <= sat_next;
    end

    assign odd_value = odd_reg;
    assign saturated = sat_reg;

endmodule

### hdl/lagrange_upsample_by_two.sv
// Top level of the 10-tap Lagrange upsample-by-two interpolator for one grid axis.
//
//  Channel   Handshake                      Payload
//  -------   ----------------------------   ---------------------------------
//  input     sample_valid / sample_ready    sample, line_start
//  result    result_valid / result_ready    even_value, odd_value, saturated
//  config    APB psel/penable/pwrite        paddr, pwdata, prdata (pready high)
//
// One sample transfer is taken in every cycle unless a stalled result backs the pipeline up;
// the sustained rate of one item per cycle is set by the four result stages advancing
// together with their valid bits: the pair, product, sum and result registers.
// A stalled result register holds only the stages behind it that are full; empty
// stages still fill, so samples keep flowing until the whole pipeline is occupied.
// Reset clears the window, the fill count, the valid bits and the weights to their
// defaults; no clearing pass follows it.
module lagrange_upsample_by_two import lup2_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          line_start,

    output logic                          result_valid,
    input  logic                          result_ready,
    output logic signed [SAMPLE_BITS-1:0] even_value,
    output logic signed [SAMPLE_BITS-1:0] odd_value,
    output logic                          saturated,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_BITS-1:0]          paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // ------------------------------------------------------------------
    // Configuration registers: five Q16 weights, one per symmetric pair.
    // Register i sits at byte address 4*i; the low address bits are ignored.
    // ------------------------------------------------------------------
    logic signed [COEF_BITS-1:0] coef_reg  [HALF_TAPS];
    logic signed [COEF_BITS-1:0] coef_next [HALF_TAPS];
    lup2_reg_t                   reg_idx;
    logic                        cfg_write;

    assign reg_idx   = lup2_reg_t'(paddr[ADDR_BITS-1:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        for (int i = 0; i < HALF_TAPS; i++)
        begin
            coef_next[i] = coef_reg[i];
        end
        if (cfg_write)
        begin
            case (reg_idx)
                REG_COEF_OUTER:  coef_next[0] = pwdata[COEF_BITS-1:0];
                REG_COEF_SECOND: coef_next[1] = pwdata[COEF_BITS-1:0];
                REG_COEF_THIRD:  coef_next[2] = pwdata[COEF_BITS-1:0];
                REG_COEF_FOURTH: coef_next[3] = pwdata[COEF_BITS-1:0];
                REG_COEF_INNER:  coef_next[4] = pwdata[COEF_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Reads return the weight sign-extended to the full data width.
    always_comb
    begin
        case (reg_idx)
            REG_COEF_OUTER:  prdata = 32'(coef_reg[0]);
            REG_COEF_SECOND: prdata = 32'(coef_reg[1]);
            REG_COEF_THIRD:  prdata = 32'(coef_reg[2]);
            REG_COEF_FOURTH: prdata = 32'(coef_reg[3]);
            REG_COEF_INNER:  prdata = 32'(coef_reg[4]);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HALF_TAPS; i++)
            begin
                coef_reg[i] <= COEF_RESET[i];
            end
        end
        else
        begin
            for (int i = 0; i < HALF_TAPS; i++)
            begin
                coef_reg[i] <= coef_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Each stage loads when the one in front of it is empty
    // or is handing its item on in the same cycle.
    // ------------------------------------------------------------------
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic result_valid_reg, result_valid_next;
    logic go_out, go3, go2;
    logic in_accept;
    logic fire;

    assign go_out       = v3_reg && (!result_valid_reg || result_ready);
    assign go3          = v2_reg && (!v3_reg || go_out);
    assign go2          = v1_reg && (!v2_reg || go3);
    assign sample_ready = !v1_reg || go2;
    assign in_accept    = sample_valid && sample_ready;

    // ------------------------------------------------------------------
    // Fill count. A line start restarts the count before the new sample is
    // counted, so a line's first result follows its tenth sample. The
    // window itself is not cleared.
    // ------------------------------------------------------------------
    logic [FILL_BITS-1:0] fill_count_reg;
    logic [FILL_BITS-1:0] fill_count_next;
    logic [FILL_BITS-1:0] fill_base;
    logic [FILL_BITS-1:0] fill_inc;

    always_comb
    begin
        fill_base       = line_start ? '0 : fill_count_reg;
        fill_inc        = (fill_base < TAPS_FILL) ? fill_base + 1'b1 : fill_base;
        fire            = (fill_inc == TAPS_FILL);
        fill_count_next = in_accept ? fill_inc : fill_count_reg;
    end

    always_comb
    begin
        v1_next           = in_accept ? fire : (go2 ? 1'b0 : v1_reg);
        v2_next           = go2 ? 1'b1 : (go3 ? 1'b0 : v2_reg);
        v3_next           = go3 ? 1'b1 : (go_out ? 1'b0 : v3_reg);
        result_valid_next = go_out ? 1'b1 : (result_ready ? 1'b0 : result_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg   <= '0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            fill_count_reg   <= fill_count_next;
            v1_reg           <= v1_next;
            v2_reg           <= v2_next;
            v3_reg           <= v3_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

    // ------------------------------------------------------------------
    // Window: a row of cells, tap 0 oldest. On every sample transfer each
    // cell takes its newer neighbour's sample and the newest cell takes the
    // incoming one. The pair sums are formed from the shifted window.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] tap      [TAPS];
    logic signed [SAMPLE_BITS-1:0] shift_in [TAPS];

    genvar g;
    generate
        for (g = 0; g < TAPS; g++)
        begin : g_cell
            if (g < TAPS - 1)
            begin : g_inner
                assign shift_in[g] = tap[g+1];
            end
            else
            begin : g_newest
                assign shift_in[g] = sample;
            end

            lup2_tap_cell #(
                .WIDTH(SAMPLE_BITS)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (in_accept),
                .data_in  (shift_in[g]),
                .data_out (tap[g])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Odd path: five pair multipliers, then the sum, round and clip.
    // ------------------------------------------------------------------
    lup2_mac_ctl_t mac_ctl;
    lup2_rs_ctl_t  rs_ctl;
    logic          load_pair;

    assign load_pair         = in_accept && fire;
    assign mac_ctl.load_pair = load_pair;
    assign mac_ctl.load_prod = go2;
    assign rs_ctl.load_sum   = go3;
    assign rs_ctl.load_out   = go_out;

    logic signed [SAMPLE_BITS+COEF_BITS:0] product [HALF_TAPS];

    generate
        for (g = 0; g < HALF_TAPS; g++)
        begin : g_pair
            lup2_mac #(
                .SAMPLE_BITS(SAMPLE_BITS)
            ) u_mac (
                .clk     (clk),
                .ctl     (mac_ctl),
                .tap_lo  (shift_in[g]),
                .tap_hi  (shift_in[TAPS-1-g]),
                .coef    (coef_reg[g]),
                .product (product[g])
            );
        end
    endgenerate

    lup2_round_sat #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_round_sat (
        .clk       (clk),
        .ctl       (rs_ctl),
        .product   (product),
        .odd_value (odd_value),
        .saturated (saturated)
    );

    // ------------------------------------------------------------------
    // Even path: the centre tap travels alongside the odd sum.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] even1_reg, even1_next;
    logic signed [SAMPLE_BITS-1:0] even2_reg, even2_next;
    logic signed [SAMPLE_BITS-1:0] even3_reg, even3_next;
    logic signed [SAMPLE_BITS-1:0] even_out_reg, even_out_next;

    always_comb
    begin
        even1_next    = load_pair ? shift_in[EVEN_TAP] : even1_reg;
        even2_next    = go2 ? even1_reg : even2_reg;
        even3_next    = go3 ? even2_reg : even3_reg;
        even_out_next = go_out ? even3_reg : even_out_reg;
    end

    always_ff @(posedge clk)
    begin
        even1_reg    <= even1_next;
        even2_reg    <= even2_next;
        even3_reg    <= even3_next;
        even_out_reg <= even_out_next;
    end

    assign even_value = even_out_reg;

`ifndef ASSERT_OFF
    // The fill count never runs past a full window.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= TAPS_FILL)
        else $error("fill count beyond window depth");

    // The first stage only fills from a transfer that completes the window.
    a_stage1_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v1_reg) |-> $past(load_pair))
        else $error("stage one filled without a full window");

    // A fresh result always comes from a full sum stage.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(v3_reg))
        else $error("result raised with an empty sum stage");

    // A clipped result sits at one end of the sample range.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && saturated) |->
            (odd_value == {1'b0, {(SAMPLE_BITS-1){1'b1}}}) ||
            (odd_value == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
        else $error("saturated flag with an unclipped value");
`endif

endmodule
